>>> hdl/gamepad_to_mouse_translator_core_defines.svh
// ----------------------------------------------------------------------------
// Gamepad to mouse translator: assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_TO_MOUSE_TRANSLATOR_CORE_DEFINES_SVH
`define GAMEPAD_TO_MOUSE_TRANSLATOR_CORE_DEFINES_SVH

// same-cycle implication
`define G2M_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define G2M_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/g2m_pkg.sv
// ----------------------------------------------------------------------------
// Gamepad to mouse translator package
// Types, codes and tables shared by the front end, queue and back end.
// ----------------------------------------------------------------------------
package g2m_pkg;

  typedef enum logic [1:0] {
    EV_KEY    = 2'd0,
    EV_LCLICK = 2'd1,
    EV_RCLICK = 2'd2,
    EV_MOVE   = 2'd3
  } event_kind_t;

  typedef enum logic [1:0] {
    KEY_S = 2'd0,
    KEY_B = 2'd1,
    KEY_E = 2'd2,
    KEY_V = 2'd3
  } key_code_t;

  typedef enum logic [2:0] {
    REG_SPEED_X       = 3'd0,
    REG_SPEED_B       = 3'd1,
    REG_SPEED_A       = 3'd2,
    REG_SPEED_CLICK   = 3'd3,
    REG_SPEED_RESTR   = 3'd4,
    REG_SPEED_TRIGGER = 3'd5,
    REG_SPEED_RIGHT   = 3'd6,
    REG_FAST_FACTOR   = 3'd7
  } reg_index_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SQX,
    BK_SQY,
    BK_SQRT,
    BK_MULA,
    BK_MULB,
    BK_FDX,
    BK_FDY,
    BK_LTH1,
    BK_LTH2,
    BK_RMUL,
    BK_RFS,
    BK_RTH1,
    BK_RTH2,
    BK_EMIT
  } back_state_t;

  localparam int SQRT_STEPS = 16;

  typedef struct packed {
    logic [7:0] speed_x;
    logic [7:0] speed_b;
    logic [7:0] speed_a;
    logic [7:0] speed_click;
    logic [7:0] speed_restricted;
    logic [7:0] speed_trigger;
    logic [7:0] speed_right;
    logic [2:0] fast_factor;
  } cfg_t;

  // edge/level bits: 0 Y, 1 B, 2 A, 3 stick click, 4 LB, 5 trigger
  typedef struct packed {
    logic [5:0]         edges;
    logic [5:0]         level;
    logic               left_act;
    logic [10:0]        speed;
    logic               kill_x;
    logic               kill_y;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic               right_act;
    logic signed [15:0] right_x;
  } job_t;

  typedef struct packed {
    event_kind_t kind;
    key_code_t   key;
  } edge_event_t;

  function automatic edge_event_t edge_event(input logic [2:0] idx);
    edge_event_t ev;
    case (idx)
      3'd0: ev = '{kind: EV_KEY,    key: KEY_S};
      3'd1: ev = '{kind: EV_KEY,    key: KEY_B};
      3'd2: ev = '{kind: EV_LCLICK, key: KEY_S};
      3'd3: ev = '{kind: EV_KEY,    key: KEY_E};
      3'd4: ev = '{kind: EV_RCLICK, key: KEY_S};
      3'd5: ev = '{kind: EV_KEY,    key: KEY_V};
      default: ev = '{kind: EV_KEY, key: KEY_S};
    endcase
    return ev;
  endfunction

endpackage

>>> hdl/g2m_front.sv
// ----------------------------------------------------------------------------
// Gamepad to mouse translator: front end
// Takes polls, finds button edges, picks the left speed and queues a job.
// ----------------------------------------------------------------------------
module g2m_front import g2m_pkg::*; #(
  parameter int TRIGGER_LEVEL = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [8:0]         in_buttons,
  input  logic [7:0]         in_right_trigger,
  input  logic signed [15:0] in_left_x,
  input  logic signed [15:0] in_left_y,
  input  logic signed [15:0] in_right_x,
  input  cfg_t               cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output job_t               job_o
);

  logic [5:0]  prev_r, prev_nxt;
  logic        a, b, x, y, rb, lb, st, bk, ls, rt;
  logic [5:0]  level;
  logic [7:0]  base;

  assign a  = in_buttons[0];
  assign b  = in_buttons[1];
  assign x  = in_buttons[2];
  assign y  = in_buttons[3];
  assign rb = in_buttons[4];
  assign lb = in_buttons[5];
  assign st = in_buttons[6];
  assign bk = in_buttons[7];
  assign ls = in_buttons[8];
  assign rt = in_right_trigger > 8'(TRIGGER_LEVEL);

  assign level    = {rt, lb, ls, a, b, y};
  assign in_stall = full_i;
  assign push_o   = in_valid && !full_i;

  always_comb begin
    if (x) begin
      base = cfg_i.speed_x;
    end else if (b) begin
      base = cfg_i.speed_b;
    end else if (a) begin
      base = cfg_i.speed_a;
    end else if (ls) begin
      base = cfg_i.speed_click;
    end else if (st || bk) begin
      base = cfg_i.speed_restricted;
    end else begin
      base = cfg_i.speed_trigger;
    end
  end

  always_comb begin
    job_o.edges     = level ^ prev_r;
    job_o.level     = level;
    job_o.left_act  = (x || b || a || st || bk || ls || rt) && !(st && bk);
    job_o.speed     = rb ? 11'(11'(base) * 11'(cfg_i.fast_factor)) : 11'(base);
    job_o.kill_x    = st;
    job_o.kill_y    = bk;
    job_o.left_x    = in_left_x;
    job_o.left_y    = in_left_y;
    job_o.right_act = y;
    job_o.right_x   = in_right_x;
    prev_nxt        = push_o ? level : prev_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

>>> hdl/g2m_queue.sv
// ----------------------------------------------------------------------------
// Gamepad to mouse translator: job queue
// Two-entry queue between front end and back end.
// ----------------------------------------------------------------------------
module g2m_queue import g2m_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic full_o,
  output logic empty_o
);

  job_t       mem_r [2];
  logic       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full_o  = cnt_r == 2'd2;
  assign empty_o = cnt_r == 2'd0;
  assign job_o   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push_i ? !wr_r : wr_r;
    rd_nxt  = pop_i ? !rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_r] <= job_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hdl/g2m_back.sv
// ----------------------------------------------------------------------------
// Gamepad to mouse translator: back end
// Square root, motion multiplies, accumulators and result sequencing.
// ----------------------------------------------------------------------------
module g2m_back import g2m_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  job_t               job_i,
  input  logic               empty_i,
  output logic               pop_o,
  input  logic [7:0]         speed_right_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_event_kind,
  output logic [1:0]         out_key_code,
  output logic               out_pressed,
  output logic signed [9:0]  out_move_x,
  output logic signed [9:0]  out_move_y,
  output logic               out_last
);

  localparam int F   = FRACTION_BITS;
  localparam int LSH = 30 - F;
  localparam int RSH = 15 - F;
  localparam int PW  = 44;
  localparam int RPW = 25;
  localparam int OW  = F + 15;
  localparam int AW  = F + 3;
  localparam int SW  = F + 1;
  localparam int TH  = 3 << (F - 1);

  function automatic logic signed [OW-1:0] neg_tz(input logic signed [PW-1:0] v);
    logic [PW-1:0] m;
    m = v[PW-1] ? PW'(-v) : PW'(v);
    m = m >> LSH;
    return v[PW-1] ? OW'(m) : -OW'(m);
  endfunction

  function automatic logic signed [OW-1:0] tz_right(input logic signed [RPW-1:0] v);
    logic [RPW-1:0] m;
    m = v[RPW-1] ? RPW'(-v) : RPW'(v);
    m = m >> RSH;
    return v[RPW-1] ? -OW'(m) : OW'(m);
  endfunction

  function automatic logic over_th(input logic signed [OW-1:0] va,
                                   input logic signed [OW-1:0] vb);
    logic [OW-1:0] ma, mb;
    logic [2*SW:0] sq;
    ma = va[OW-1] ? OW'(-va) : OW'(va);
    mb = vb[OW-1] ? OW'(-vb) : OW'(vb);
    sq = (2*SW+1)'(SW'(ma)) * (2*SW+1)'(SW'(ma)) + (2*SW+1)'(SW'(mb)) * (2*SW+1)'(SW'(mb));
    return (ma >= OW'(TH)) || (mb >= OW'(TH)) || (sq >= (2*SW+1)'(TH * TH));
  endfunction

  function automatic logic signed [9:0] counts(input logic signed [OW-1:0] v);
    logic [OW-1:0] m;
    logic signed [9:0] c;
    m = v[OW-1] ? OW'(-v) : OW'(v);
    m = m >> F;
    if (v[OW-1]) begin
      c = (m > OW'(512)) ? -10'sd512 : 10'(-m);
    end else begin
      c = (m > OW'(511)) ? 10'sd511 : 10'(m);
    end
    return c;
  endfunction

  back_state_t        state_r, state_nxt;
  job_t               job_r, job_nxt;
  logic [5:0]         pend_r, pend_nxt;
  logic               lmove_r, lmove_nxt, rmove_r, rmove_nxt;
  logic [31:0]        sq_r, sq_nxt;
  logic [17:0]        rem_r, rem_nxt;
  logic [15:0]        root_r, root_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [26:0]        ms_r, ms_nxt;
  logic signed [PW-1:0]  prod_r, prod_nxt;
  logic signed [RPW-1:0] rprod_r, rprod_nxt;
  logic signed [OW-1:0]  fdx_r, fdx_nxt, fdy_r, fdy_nxt, fs_r, fs_nxt;
  logic signed [OW-1:0]  sumx_r, sumx_nxt, sumy_r, sumy_nxt;
  logic signed [OW-1:0]  lmx_r, lmx_nxt, lmy_r, lmy_nxt, rmv_r, rmv_nxt;
  logic               ovf_r, ovf_nxt;
  logic signed [AW-1:0]  accx_r, accx_nxt, accy_r, accy_nxt, racc_r, racc_nxt;
  logic               ov_r, ov_nxt;
  logic [1:0]         kind_r, kind_nxt, key_r, key_nxt;
  logic               pr_r, pr_nxt, last_r, last_nxt;
  logic signed [9:0]  mx_r, mx_nxt, my_r, my_nxt;

  logic               lzero, rzero, slot_free, any_left;
  logic [19:0]        remsh, trial;
  logic [2:0]         idx;
  edge_event_t        ev;

  assign lzero     = (job_r.left_x == '0) && (job_r.left_y == '0);
  assign rzero     = job_r.right_x == '0;
  assign slot_free = !ov_r || !out_stall;
  assign any_left  = (pend_r != '0) || lmove_r || rmove_r;
  assign remsh     = {rem_r, sq_r[31:30]};
  assign trial     = 20'({root_r, 2'b01});
  assign ev        = edge_event(idx);

  always_comb begin
    idx = '0;
    for (int i = 5; i >= 0; i--) begin
      if (pend_r[i]) begin
        idx = 3'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!empty_i) begin
          if (job_i.left_act) begin
            state_nxt = (job_i.left_x == '0 && job_i.left_y == '0) ? BK_LTH2 : BK_SQX;
          end else if (job_i.right_act) begin
            state_nxt = (job_i.right_x == '0) ? BK_RTH2 : BK_RMUL;
          end else begin
            state_nxt = BK_EMIT;
          end
        end
      end
      BK_SQX:  state_nxt = BK_SQY;
      BK_SQY:  state_nxt = BK_SQRT;
      BK_SQRT: state_nxt = (cnt_r == 4'(SQRT_STEPS - 1)) ? BK_MULA : BK_SQRT;
      BK_MULA: state_nxt = BK_MULB;
      BK_MULB: state_nxt = BK_FDX;
      BK_FDX:  state_nxt = BK_FDY;
      BK_FDY:  state_nxt = BK_LTH1;
      BK_LTH1: state_nxt = BK_LTH2;
      BK_LTH2: begin
        if (job_r.right_act) begin
          state_nxt = rzero ? BK_RTH2 : BK_RMUL;
        end else begin
          state_nxt = BK_EMIT;
        end
      end
      BK_RMUL: state_nxt = BK_RFS;
      BK_RFS:  state_nxt = BK_RTH1;
      BK_RTH1: state_nxt = BK_RTH2;
      BK_RTH2: state_nxt = BK_EMIT;
      BK_EMIT: state_nxt = any_left ? BK_EMIT : BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop_o     = 1'b0;
    job_nxt   = job_r;
    pend_nxt  = pend_r;
    lmove_nxt = lmove_r;
    rmove_nxt = rmove_r;
    sq_nxt    = sq_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    ms_nxt    = ms_r;
    prod_nxt  = prod_r;
    rprod_nxt = rprod_r;
    fdx_nxt   = fdx_r;
    fdy_nxt   = fdy_r;
    fs_nxt    = fs_r;
    sumx_nxt  = sumx_r;
    sumy_nxt  = sumy_r;
    lmx_nxt   = lmx_r;
    lmy_nxt   = lmy_r;
    rmv_nxt   = rmv_r;
    ovf_nxt   = ovf_r;
    accx_nxt  = accx_r;
    accy_nxt  = accy_r;
    racc_nxt  = racc_r;
    ov_nxt    = out_stall ? ov_r : 1'b0;
    kind_nxt  = kind_r;
    key_nxt   = key_r;
    pr_nxt    = pr_r;
    last_nxt  = last_r;
    mx_nxt    = mx_r;
    my_nxt    = my_r;
    case (state_r)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          job_nxt   = job_i;
          pend_nxt  = job_i.edges;
          lmove_nxt = 1'b0;
          rmove_nxt = 1'b0;
        end
      end
      BK_SQX: begin
        sq_nxt = 32'(32'(job_r.left_x) * 32'(job_r.left_x));
      end
      BK_SQY: begin
        sq_nxt   = sq_r + 32'(32'(job_r.left_y) * 32'(job_r.left_y));
        rem_nxt  = '0;
        root_nxt = '0;
        cnt_nxt  = '0;
      end
      BK_SQRT: begin
        if (remsh >= trial) begin
          rem_nxt  = 18'(remsh - trial);
          root_nxt = {root_r[14:0], 1'b1};
        end else begin
          rem_nxt  = 18'(remsh);
          root_nxt = {root_r[14:0], 1'b0};
        end
        sq_nxt  = sq_r << 2;
        cnt_nxt = cnt_r + 4'd1;
      end
      BK_MULA: begin
        ms_nxt = 27'(27'(root_r) * 27'(job_r.speed));
      end
      BK_MULB: begin
        prod_nxt = PW'(job_r.left_y) * $signed(PW'(ms_r));
      end
      BK_FDX: begin
        fdx_nxt  = neg_tz(prod_r);
        prod_nxt = PW'(job_r.left_x) * $signed(PW'(ms_r));
      end
      BK_FDY: begin
        fdy_nxt = neg_tz(prod_r);
      end
      BK_LTH1: begin
        ovf_nxt  = over_th(fdx_r, fdy_r);
        sumx_nxt = fdx_r + OW'(accx_r);
        sumy_nxt = fdy_r + OW'(accy_r);
      end
      BK_LTH2: begin
        if (lzero) begin
          if (accx_r != '0 || accy_r != '0) begin
            lmove_nxt = 1'b1;
            lmx_nxt   = OW'(accx_r);
            lmy_nxt   = OW'(accy_r);
            accx_nxt  = '0;
            accy_nxt  = '0;
          end
        end else if (ovf_r) begin
          lmove_nxt = 1'b1;
          lmx_nxt   = fdx_r;
          lmy_nxt   = fdy_r;
          accx_nxt  = '0;
          accy_nxt  = '0;
        end else if (over_th(sumx_r, sumy_r)) begin
          lmove_nxt = 1'b1;
          lmx_nxt   = sumx_r;
          lmy_nxt   = sumy_r;
          accx_nxt  = '0;
          accy_nxt  = '0;
        end else begin
          accx_nxt = AW'(sumx_r);
          accy_nxt = AW'(sumy_r);
        end
      end
      BK_RMUL: begin
        rprod_nxt = RPW'(job_r.right_x) * $signed(RPW'(speed_right_i));
      end
      BK_RFS: begin
        fs_nxt = tz_right(rprod_r);
      end
      BK_RTH1: begin
        ovf_nxt  = over_th(fs_r, '0);
        sumx_nxt = fs_r + OW'(racc_r);
      end
      BK_RTH2: begin
        if (rzero) begin
          if (racc_r != '0) begin
            rmove_nxt = 1'b1;
            rmv_nxt   = -OW'(racc_r);
            racc_nxt  = '0;
          end
        end else if (ovf_r) begin
          rmove_nxt = 1'b1;
          rmv_nxt   = -fs_r;
          racc_nxt  = '0;
        end else if (over_th(sumx_r, '0)) begin
          rmove_nxt = 1'b1;
          rmv_nxt   = -sumx_r;
          racc_nxt  = '0;
        end else begin
          racc_nxt = AW'(sumx_r);
        end
      end
      BK_EMIT: begin
        if (slot_free && any_left) begin
          ov_nxt = 1'b1;
          if (pend_r != '0) begin
            pend_nxt      = pend_r & ~(6'd1 << idx);
            kind_nxt      = ev.kind;
            key_nxt       = ev.key;
            pr_nxt        = job_r.level[idx];
            mx_nxt        = '0;
            my_nxt        = '0;
            last_nxt      = (pend_nxt == '0) && !lmove_r && !rmove_r;
          end else if (lmove_r) begin
            lmove_nxt = 1'b0;
            kind_nxt  = EV_MOVE;
            key_nxt   = KEY_S;
            pr_nxt    = 1'b0;
            mx_nxt    = job_r.kill_x ? 10'sd0 : counts(lmx_r);
            my_nxt    = job_r.kill_y ? 10'sd0 : counts(lmy_r);
            last_nxt  = !rmove_r;
          end else begin
            rmove_nxt = 1'b0;
            kind_nxt  = EV_MOVE;
            key_nxt   = KEY_S;
            pr_nxt    = 1'b0;
            mx_nxt    = '0;
            my_nxt    = counts(rmv_r);
            last_nxt  = 1'b1;
          end
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  assign out_valid      = ov_r;
  assign out_event_kind = kind_r;
  assign out_key_code   = key_r;
  assign out_pressed    = pr_r;
  assign out_move_x     = mx_r;
  assign out_move_y     = my_r;
  assign out_last       = last_r;

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    sq_r    <= sq_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    cnt_r   <= cnt_nxt;
    ms_r    <= ms_nxt;
    prod_r  <= prod_nxt;
    rprod_r <= rprod_nxt;
    fdx_r   <= fdx_nxt;
    fdy_r   <= fdy_nxt;
    fs_r    <= fs_nxt;
    sumx_r  <= sumx_nxt;
    sumy_r  <= sumy_nxt;
    lmx_r   <= lmx_nxt;
    lmy_r   <= lmy_nxt;
    rmv_r   <= rmv_nxt;
    ovf_r   <= ovf_nxt;
    kind_r  <= kind_nxt;
    key_r   <= key_nxt;
    pr_r    <= pr_nxt;
    last_r  <= last_nxt;
    mx_r    <= mx_nxt;
    my_r    <= my_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      pend_r  <= '0;
      lmove_r <= 1'b0;
      rmove_r <= 1'b0;
      accx_r  <= '0;
      accy_r  <= '0;
      racc_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      lmove_r <= lmove_nxt;
      rmove_r <= rmove_nxt;
      accx_r  <= accx_nxt;
      accy_r  <= accy_nxt;
      racc_r  <= racc_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

>>> hdl/gamepad_to_mouse_translator_core.sv
// ----------------------------------------------------------------------------
// Gamepad to mouse translator core
// Turns gamepad polls into key, click and mouse move events.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one gamepad poll per transfer (valid/stall).
//   out_* : zero to eight events per poll, in order; out_last marks the
//           final event of a poll. A poll with no events gives no transfer.
//   cfg_* : APB-style port, registers at byte address 4*index; the user must
//           write them only while the block is idle; the block does not check.
// The back end works through one poll at a time and emits its events back to
//   back while out_stall is low; the 16-iteration square root and the serial
//   multiplies in the back end limit how fast polls are worked through.
// A two-entry queue lets the front end take further polls while the back
//   end works; in_stall rises only when the queue is full.
// A stalled result waits in the output register and the back end holds in its emit state.
// Reset: registers return to defaults, accumulators and button history clear.
// ----------------------------------------------------------------------------
`include "gamepad_to_mouse_translator_core_defines.svh"

module gamepad_to_mouse_translator_core import g2m_pkg::*; #(
  parameter int TRIGGER_LEVEL = 30,
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [8:0]         in_buttons,
  input  logic [7:0]         in_right_trigger,
  input  logic signed [15:0] in_left_x,
  input  logic signed [15:0] in_left_y,
  input  logic signed [15:0] in_right_x,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_event_kind,
  output logic [1:0]         out_key_code,
  output logic               out_pressed,
  output logic signed [9:0]  out_move_x,
  output logic signed [9:0]  out_move_y,
  output logic               out_last,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  cfg_t       cfg_r, cfg_nxt;
  reg_index_t idx;
  logic       wr_en;
  logic       push, pop, full, empty;
  job_t       job_in, job_out;
  logic [2:0] fast_factor_r;

  assign idx           = reg_index_t'(cfg_paddr[4:2]);
  assign wr_en         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready    = 1'b1;
  assign fast_factor_r = cfg_r.fast_factor;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_SPEED_X:       cfg_nxt.speed_x          = cfg_pwdata[7:0];
        REG_SPEED_B:       cfg_nxt.speed_b          = cfg_pwdata[7:0];
        REG_SPEED_A:       cfg_nxt.speed_a          = cfg_pwdata[7:0];
        REG_SPEED_CLICK:   cfg_nxt.speed_click      = cfg_pwdata[7:0];
        REG_SPEED_RESTR:   cfg_nxt.speed_restricted = cfg_pwdata[7:0];
        REG_SPEED_TRIGGER: cfg_nxt.speed_trigger    = cfg_pwdata[7:0];
        REG_SPEED_RIGHT:   cfg_nxt.speed_right      = cfg_pwdata[7:0];
        REG_FAST_FACTOR:   cfg_nxt.fast_factor      = cfg_pwdata[2:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SPEED_X:       cfg_prdata = 32'(cfg_r.speed_x);
      REG_SPEED_B:       cfg_prdata = 32'(cfg_r.speed_b);
      REG_SPEED_A:       cfg_prdata = 32'(cfg_r.speed_a);
      REG_SPEED_CLICK:   cfg_prdata = 32'(cfg_r.speed_click);
      REG_SPEED_RESTR:   cfg_prdata = 32'(cfg_r.speed_restricted);
      REG_SPEED_TRIGGER: cfg_prdata = 32'(cfg_r.speed_trigger);
      REG_SPEED_RIGHT:   cfg_prdata = 32'(cfg_r.speed_right);
      REG_FAST_FACTOR:   cfg_prdata = 32'(cfg_r.fast_factor);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{speed_x: 8'd20, speed_b: 8'd25, speed_a: 8'd30, speed_click: 8'd15,
                 speed_restricted: 8'd28, speed_trigger: 8'd40, speed_right: 8'd220,
                 fast_factor: 3'd3};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  g2m_front #(
    .TRIGGER_LEVEL (TRIGGER_LEVEL)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_buttons       (in_buttons),
    .in_right_trigger (in_right_trigger),
    .in_left_x        (in_left_x),
    .in_left_y        (in_left_y),
    .in_right_x       (in_right_x),
    .cfg_i            (cfg_r),
    .full_i           (full),
    .push_o           (push),
    .job_o            (job_in)
  );

  g2m_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_out),
    .full_o  (full),
    .empty_o (empty)
  );

  g2m_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_i          (job_out),
    .empty_i        (empty),
    .pop_o          (pop),
    .speed_right_i  (cfg_r.speed_right),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_kind (out_event_kind),
    .out_key_code   (out_key_code),
    .out_pressed    (out_pressed),
    .out_move_x     (out_move_x),
    .out_move_y     (out_move_y),
    .out_last       (out_last)
  );

  `G2M_ASSERT_NOW(a_move_zero, out_valid && out_event_kind != EV_MOVE, out_move_x == '0 && out_move_y == '0, "key or click event carries a move")
  `G2M_ASSERT_NOW(a_key_zero, out_valid && out_event_kind != EV_KEY, out_key_code == '0, "non-key event carries a key code")
  `G2M_ASSERT_NOW(a_move_press, out_valid && out_event_kind == EV_MOVE, !out_pressed, "move event marked as pressed")
  `G2M_ASSERT_NEXT(a_ff_write, wr_en && idx == REG_FAST_FACTOR, fast_factor_r == $past(cfg_pwdata[2:0]), "fast factor write lost")

endmodule
